>>> design/gcpfra_pkg.sv
`timescale 1ns / 1ps

package gcpfra_pkg;

    localparam int PAGE_BLOCKS_MAX_DEF = 1024;
    localparam int RUNS_MAX_DEF        = 512;

    localparam int CMD_W        = 3;
    localparam int COUNT_W      = 8;
    localparam int INDEX_W      = 10;
    localparam int GRANT_W      = 10;
    localparam int FU_W         = 10;
    localparam int PB_W         = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    localparam logic [CMD_W-1:0] CMD_INIT       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BEGIN_MARK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWEEP      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_VAR_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BLOCKS  = 2'd2;

    localparam logic [PB_W-1:0] PAGE_BLOCKS_RST = 11'd1024;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COUNT_W-1:0] block_count;
        logic [INDEX_W-1:0] block_index;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [GRANT_W-1:0] granted_block;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLR_ALL,
        OP_CLR_MARK,
        OP_INIT_RUN,
        OP_MARK,
        OP_SW_START,
        OP_SW_RD,
        OP_SW_EV,
        OP_AL_START,
        OP_AL_RD,
        OP_AL_EV,
        OP_AL_ZERO,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        logic clr_last;
        logic pending;
        logic sw_end;
        logic al_end;
        logic al_fit;
        logic al_multi;
        logic zero_last;
    } dp_status_t;

endpackage

>>> design/gcpfra_dp.sv
`timescale 1ns / 1ps

module gcpfra_dp #(
    parameter int PAGE_BLOCKS_MAX = gcpfra_pkg::PAGE_BLOCKS_MAX_DEF,
    parameter int RUNS_MAX        = gcpfra_pkg::RUNS_MAX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gcpfra_pkg::dp_op_t                   op,
    output gcpfra_pkg::dp_status_t               st,
    input  gcpfra_pkg::in_item_t                 in_data,
    output gcpfra_pkg::out_item_t                out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gcpfra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcpfra_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gcpfra_pkg::*;

    localparam int AW        = $clog2(PAGE_BLOCKS_MAX);
    localparam int BW        = AW + 1;
    localparam int RW        = $clog2(RUNS_MAX);
    localparam int TW        = RW + 1;
    localparam int MW        = RW + 1;
    localparam int MEM_DEPTH = 2 ** MW;

    typedef struct packed {
        logic [BW-1:0] start;
        logic [BW-1:0] len;
    } run_entry_t;

    // Memories. The run store holds two banks; a sweep reads one and builds the other.
    logic             mark_mem [PAGE_BLOCKS_MAX];
    logic [COUNT_W-1:0] lens_mem [PAGE_BLOCKS_MAX];
    run_entry_t       run_mem  [MEM_DEPTH];

    logic               var_mode_reg;
    logic [FU_W-1:0]    first_usable_reg;
    logic [PB_W-1:0]    page_blocks_reg;
    logic [COUNT_W-1:0] block_count_reg;
    logic [INDEX_W-1:0] block_index_reg;
    logic [AW-1:0]      clr_idx_reg, clr_idx_next;
    logic               pending_reg, pending_next;
    logic [TW-1:0]      total_reg, total_next;
    logic [TW-1:0]      cursor_reg, cursor_next;
    logic               bank_reg, bank_next;
    logic [BW-1:0]      bid_reg, bid_next;
    logic [TW-1:0]      ri_reg, ri_next;
    logic [TW-1:0]      old_total_reg, old_total_next;
    logic [TW-1:0]      k_reg, k_next;
    logic [BW-1:0]      tail_start_reg, tail_start_next;
    logic [BW-1:0]      tail_len_reg, tail_len_next;
    logic [COUNT_W-1:0] zi_reg, zi_next;
    logic [BW-1:0]      al_start_reg, al_start_next;
    logic               res_status_reg, res_status_next;
    logic [GRANT_W-1:0] res_granted_reg, res_granted_next;
    out_item_t          out_data_reg;

    run_entry_t         run_rd_reg;
    logic               mark_rd_reg;
    logic [COUNT_W-1:0] lens_rd_reg;

    logic               mark_we, mark_wd;
    logic [AW-1:0]      mark_wa;
    logic               lens_we;
    logic [AW-1:0]      lens_wa;
    logic [COUNT_W-1:0] lens_wd;
    logic               run_we;
    logic [MW-1:0]      run_wa, run_ra;
    run_entry_t         run_wd;

    logic [BW-1:0]      last;
    logic               fu_in;
    logic [COUNT_W-1:0] n_val;
    logic [COUNT_W-1:0] need;
    logic [BW-1:0]      rem;
    logic               run_ok, skip, match, add_en, merge;
    logic [31:0]        src_cnt32, cnt32;
    logic [BW-1:0]      cnt;
    logic [BW-1:0]      al_new_len;
    logic [TW-1:0]      total_m1;

    assign cfg_ready = 1'b1;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (32'(page_blocks_reg) > PAGE_BLOCKS_MAX)
        begin
            last = BW'(PAGE_BLOCKS_MAX);
        end
        else
        begin
            last = BW'(page_blocks_reg);
        end
        fu_in  = 32'(first_usable_reg) < 32'(last);
        n_val  = (block_count_reg == '0) ? COUNT_W'(1) : block_count_reg;
        need   = var_mode_reg ? n_val : COUNT_W'(1);
        rem    = last - bid_reg;
        run_ok = ri_reg < old_total_reg;
        skip   = run_ok && (run_rd_reg.len == '0 || run_rd_reg.start < bid_reg);
        match  = run_ok && !skip && (run_rd_reg.start == bid_reg);
        if (match)
        begin
            src_cnt32 = 32'(run_rd_reg.len);
        end
        else if (var_mode_reg && lens_rd_reg != '0)
        begin
            src_cnt32 = 32'(lens_rd_reg);
        end
        else
        begin
            src_cnt32 = 32'd1;
        end
        cnt32      = (src_cnt32 > 32'(rem)) ? 32'(rem) : src_cnt32;
        cnt        = BW'(cnt32);
        add_en     = match || (!skip && !mark_rd_reg);
        merge      = (total_reg != '0) && (tail_start_reg + tail_len_reg == bid_reg);
        al_new_len = run_rd_reg.len - BW'(need);
        total_m1   = total_reg - TW'(1);
    end

    always_comb
    begin
        st.clr_last  = clr_idx_reg == AW'(PAGE_BLOCKS_MAX - 1);
        st.pending   = pending_reg;
        st.sw_end    = bid_reg >= last;
        st.al_end    = k_reg >= total_reg;
        st.al_fit    = 32'(run_rd_reg.len) >= 32'(need);
        st.al_multi  = var_mode_reg && (n_val > COUNT_W'(1));
        st.zero_last = zi_reg == n_val - COUNT_W'(1);
    end

    always_comb
    begin
        clr_idx_next     = clr_idx_reg;
        pending_next     = pending_reg;
        total_next       = total_reg;
        cursor_next      = cursor_reg;
        bank_next        = bank_reg;
        bid_next         = bid_reg;
        ri_next          = ri_reg;
        old_total_next   = old_total_reg;
        k_next           = k_reg;
        tail_start_next  = tail_start_reg;
        tail_len_next    = tail_len_reg;
        zi_next          = zi_reg;
        al_start_next    = al_start_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        mark_we = 1'b0;
        mark_wa = clr_idx_reg;
        mark_wd = 1'b0;
        lens_we = 1'b0;
        lens_wa = clr_idx_reg;
        lens_wd = '0;
        run_we  = 1'b0;
        run_wa  = {bank_reg, k_reg[RW-1:0]};
        run_wd  = '0;
        run_ra  = {bank_reg, k_reg[RW-1:0]};

        case (op)
            OP_ACCEPT:
            begin
                res_status_next  = 1'b0;
                res_granted_next = '0;
            end
            OP_CLR_ALL, OP_CLR_MARK:
            begin
                mark_we = 1'b1;
                lens_we = (op == OP_CLR_ALL);
                if (st.clr_last)
                begin
                    clr_idx_next = '0;
                    if (op == OP_CLR_MARK)
                    begin
                        pending_next = 1'b1;
                    end
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            OP_INIT_RUN:
            begin
                cursor_next  = '0;
                pending_next = 1'b0;
                total_next   = '0;
                if (fu_in)
                begin
                    run_we       = 1'b1;
                    run_wa       = {bank_reg, RW'(0)};
                    run_wd.start = BW'(first_usable_reg);
                    run_wd.len   = last - BW'(first_usable_reg);
                    total_next   = TW'(1);
                end
            end
            OP_MARK:
            begin
                if (32'(block_index_reg) < PAGE_BLOCKS_MAX)
                begin
                    mark_we = 1'b1;
                    mark_wa = AW'(block_index_reg);
                    mark_wd = 1'b1;
                end
            end
            OP_SW_START:
            begin
                bid_next       = fu_in ? BW'(first_usable_reg) : last;
                ri_next        = cursor_reg;
                old_total_next = total_reg;
                total_next     = '0;
                cursor_next    = '0;
            end
            OP_SW_RD:
            begin
                run_ra = {bank_reg, ri_reg[RW-1:0]};
                if (st.sw_end)
                begin
                    bank_next    = !bank_reg;
                    pending_next = 1'b0;
                end
            end
            OP_SW_EV:
            begin
                if (skip)
                begin
                    ri_next = ri_reg + TW'(1);
                end
                else
                begin
                    if (match)
                    begin
                        ri_next = ri_reg + TW'(1);
                    end
                    else if (!mark_rd_reg && var_mode_reg)
                    begin
                        lens_we = 1'b1;
                        lens_wa = bid_reg[AW-1:0];
                        lens_wd = '0;
                    end
                    bid_next = bid_reg + cnt;
                    if (add_en)
                    begin
                        // Adjacent free runs fold into the tail run.
                        if (merge)
                        begin
                            tail_len_next = tail_len_reg + cnt;
                            run_we        = 1'b1;
                            run_wa        = {!bank_reg, total_m1[RW-1:0]};
                            run_wd.start  = tail_start_reg;
                            run_wd.len    = tail_len_reg + cnt;
                        end
                        else if (total_reg < TW'(RUNS_MAX))
                        begin
                            tail_start_next = bid_reg;
                            tail_len_next   = cnt;
                            run_we          = 1'b1;
                            run_wa          = {!bank_reg, total_reg[RW-1:0]};
                            run_wd.start    = bid_reg;
                            run_wd.len      = cnt;
                            total_next      = total_reg + TW'(1);
                        end
                    end
                end
            end
            OP_AL_START:
            begin
                k_next = cursor_reg;
            end
            OP_AL_RD:
            begin
                if (st.al_end)
                begin
                    res_status_next = 1'b1;
                end
            end
            OP_AL_EV:
            begin
                if (st.al_fit)
                begin
                    run_we           = 1'b1;
                    run_wd.start     = run_rd_reg.start + BW'(need);
                    run_wd.len       = al_new_len;
                    res_granted_next = GRANT_W'(32'(run_rd_reg.start));
                    if (al_new_len == '0)
                    begin
                        cursor_next = cursor_reg + TW'(1);
                    end
                    if (var_mode_reg)
                    begin
                        mark_we       = 1'b1;
                        mark_wa       = run_rd_reg.start[AW-1:0];
                        mark_wd       = 1'b1;
                        lens_we       = 1'b1;
                        lens_wa       = run_rd_reg.start[AW-1:0];
                        lens_wd       = n_val;
                        al_start_next = run_rd_reg.start;
                        zi_next       = COUNT_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + TW'(1);
                    // In fixed mode only empty runs fail, and the cursor skips them.
                    if (!var_mode_reg)
                    begin
                        cursor_next = cursor_reg + TW'(1);
                    end
                end
            end
            OP_AL_ZERO:
            begin
                lens_we = 1'b1;
                lens_wa = AW'(32'(al_start_reg) + 32'(zi_reg));
                lens_wd = '0;
                zi_next = zi_reg + COUNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_mode_reg     <= 1'b1;
            first_usable_reg <= '0;
            page_blocks_reg  <= PAGE_BLOCKS_RST;
            clr_idx_reg      <= '0;
            pending_reg      <= 1'b0;
            total_reg        <= '0;
            cursor_reg       <= '0;
            bank_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_VAR_MODE:     var_mode_reg     <= cfg_data[0];
                    CFG_FIRST_USABLE: first_usable_reg <= cfg_data[FU_W-1:0];
                    CFG_PAGE_BLOCKS:  page_blocks_reg  <= cfg_data[PB_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            clr_idx_reg <= clr_idx_next;
            pending_reg <= pending_next;
            total_reg   <= total_next;
            cursor_reg  <= cursor_next;
            bank_reg    <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_ACCEPT)
        begin
            block_count_reg <= in_data.block_count;
            block_index_reg <= in_data.block_index;
        end
        if (op == OP_LOAD_OUT)
        begin
            out_data_reg.status        <= res_status_reg;
            out_data_reg.granted_block <= res_granted_reg;
        end
        bid_reg         <= bid_next;
        ri_reg          <= ri_next;
        old_total_reg   <= old_total_next;
        k_reg           <= k_next;
        tail_start_reg  <= tail_start_next;
        tail_len_reg    <= tail_len_next;
        zi_reg          <= zi_next;
        al_start_reg    <= al_start_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd_reg <= mark_mem[bid_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (lens_we)
        begin
            lens_mem[lens_wa] <= lens_wd;
        end
        lens_rd_reg <= lens_mem[bid_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            run_mem[run_wa] <= run_wd;
        end
        run_rd_reg <= run_mem[run_ra];
    end

endmodule

>>> design/gcpfra_ctrl.sv
`timescale 1ns / 1ps

module gcpfra_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [gcpfra_pkg::CMD_W-1:0]     in_cmd,
    output logic                             in_stall,
    output logic                             out_valid,
    input  logic                             out_stall,
    output gcpfra_pkg::dp_op_t               op,
    input  gcpfra_pkg::dp_status_t           st
);
    import gcpfra_pkg::*;

    typedef enum logic [13:0] {
        S_RST_CLR  = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_CLR_ALL  = 14'b00000000000100,
        S_CLR_MARK = 14'b00000000001000,
        S_INIT_RUN = 14'b00000000010000,
        S_MARK     = 14'b00000000100000,
        S_SW_START = 14'b00000001000000,
        S_SW_RD    = 14'b00000010000000,
        S_SW_EV    = 14'b00000100000000,
        S_AL_START = 14'b00001000000000,
        S_AL_RD    = 14'b00010000000000,
        S_AL_EV    = 14'b00100000000000,
        S_AL_ZERO  = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic             out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_RST_CLR:
            begin
                op = OP_CLR_ALL;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op       = OP_ACCEPT;
                    cmd_next = in_cmd;
                    case (in_cmd)
                        CMD_INIT:       state_next = S_CLR_ALL;
                        CMD_ALLOC:      state_next = st.pending ? S_SW_START : S_AL_START;
                        CMD_BEGIN_MARK: state_next = S_CLR_MARK;
                        CMD_MARK:       state_next = S_MARK;
                        CMD_SWEEP:      state_next = st.pending ? S_SW_START : S_DONE;
                        default:        state_next = S_DONE;
                    endcase
                end
            end
            S_CLR_ALL:
            begin
                op = OP_CLR_ALL;
                if (st.clr_last)
                begin
                    state_next = S_INIT_RUN;
                end
            end
            S_CLR_MARK:
            begin
                op = OP_CLR_MARK;
                if (st.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_INIT_RUN:
            begin
                op         = OP_INIT_RUN;
                state_next = S_DONE;
            end
            S_MARK:
            begin
                op         = OP_MARK;
                state_next = S_DONE;
            end
            S_SW_START:
            begin
                op         = OP_SW_START;
                state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                op = OP_SW_RD;
                if (st.sw_end)
                begin
                    state_next = (cmd_reg == CMD_ALLOC) ? S_AL_START : S_DONE;
                end
                else
                begin
                    state_next = S_SW_EV;
                end
            end
            S_SW_EV:
            begin
                op         = OP_SW_EV;
                state_next = S_SW_RD;
            end
            S_AL_START:
            begin
                op         = OP_AL_START;
                state_next = S_AL_RD;
            end
            S_AL_RD:
            begin
                op         = OP_AL_RD;
                state_next = st.al_end ? S_DONE : S_AL_EV;
            end
            S_AL_EV:
            begin
                op = OP_AL_EV;
                if (st.al_fit)
                begin
                    state_next = st.al_multi ? S_AL_ZERO : S_DONE;
                end
                else
                begin
                    state_next = S_AL_RD;
                end
            end
            S_AL_ZERO:
            begin
                op = OP_AL_ZERO;
                if (st.zero_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // The result register may still hold an earlier beat.
                if (!out_valid_reg || !out_stall)
                begin
                    op             = OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_CLR;
            cmd_reg       <= CMD_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/gc_page_free_run_allocator.sv
// Init clears the mark and length memories, then writes the first free run; begin mark
// clears the marks; mark sets one mark; unknown commands and a sweep with nothing pending
// go straight to the result. Allocate checks runs in turn from the cursor, then in variable
// mode clears the rest of the granted lengths; a pending sweep first rebuilds the runs.
// One item is in flight at a time; the sweep loop and memory ports set the rate. After reset
// both memories are cleared with in_stall high; configuration writes are taken throughout.
`timescale 1ns / 1ps

module gc_page_free_run_allocator #(
    parameter int PAGE_BLOCKS_MAX = gcpfra_pkg::PAGE_BLOCKS_MAX_DEF,
    parameter int RUNS_MAX        = gcpfra_pkg::RUNS_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  gcpfra_pkg::in_item_t              in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output gcpfra_pkg::out_item_t             out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcpfra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcpfra_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gcpfra_pkg::*;

    dp_op_t     op;
    dp_status_t st;

    gcpfra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .op        (op),
        .st        (st)
    );

    gcpfra_dp #(
        .PAGE_BLOCKS_MAX (PAGE_BLOCKS_MAX),
        .RUNS_MAX        (RUNS_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .st        (st),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

>>> design/gcpfra_checker.sv
`timescale 1ns / 1ps

module gcpfra_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  gcpfra_pkg::out_item_t out_data
);
    import gcpfra_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Only one item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    // A failed allocate grants no block.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.granted_block == '0)
        else $error("failure result carries a block index");

    // A new result only appears after the block was busy.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work");

endmodule

bind gc_page_free_run_allocator gcpfra_checker u_gcpfra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import gcpfra_pkg::*;

    localparam int NBLK = 1024;
    localparam int NRUN = 512;
    localparam longint CYCLE_LIMIT = 50000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gc_page_free_run_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the page state.
    bit          sh_var_mode;
    bit [9:0]    sh_first;
    bit [10:0]   sh_pages;
    bit          sh_mark [NBLK];
    bit [7:0]    sh_len [NBLK];
    int unsigned sh_rs [NRUN];
    int unsigned sh_rl [NRUN];
    int unsigned os [NRUN];
    int unsigned ol [NRUN];
    int unsigned sh_total;
    int unsigned sh_cursor;
    bit          sh_pending;

    in_item_t  pending_items [$];
    out_item_t expected_grants [$];
    int  error_count;
    longint cycle_count;
    bit  hold_sender;
    bit  draining;

    function automatic int unsigned page_last();
        return (sh_pages > NBLK) ? NBLK : sh_pages;
    endfunction

    function automatic void push_run(int unsigned s, int unsigned l);
        if (sh_total > 0 && sh_rs[sh_total-1] + sh_rl[sh_total-1] == s)
            sh_rl[sh_total-1] += l;
        else if (sh_total < NRUN)
        begin
            sh_rs[sh_total] = s;
            sh_rl[sh_total] = l;
            sh_total++;
        end
    endfunction

    function automatic void rebuild_runs();
        int unsigned last, bid, ri, old_total, cnt;
        last = page_last();
        bid = sh_first;
        ri = sh_cursor;
        old_total = sh_total;
        for (int i = 0; i < NRUN; i++)
        begin
            os[i] = sh_rs[i];
            ol[i] = sh_rl[i];
        end
        sh_total = 0;
        sh_cursor = 0;
        while (bid < last)
        begin
            while (ri < old_total && (ol[ri] == 0 || os[ri] < bid))
                ri++;
            if (ri < old_total && os[ri] == bid)
            begin
                cnt = ol[ri];
                if (cnt > last - bid) cnt = last - bid;
                push_run(bid, cnt);
                ri++;
                bid += cnt;
            end
            else
            begin
                cnt = 1;
                if (sh_var_mode && sh_len[bid] != 0) cnt = sh_len[bid];
                if (cnt > last - bid) cnt = last - bid;
                if (!sh_mark[bid])
                begin
                    if (sh_var_mode) sh_len[bid] = 0;
                    push_run(bid, cnt);
                end
                bid += cnt;
            end
        end
        sh_pending = 0;
    endfunction

    function automatic bit take_blocks(int unsigned n, output int unsigned granted);
        int unsigned bid;
        granted = 0;
        if (sh_pending) rebuild_runs();
        if (!sh_var_mode)
        begin
            while (sh_cursor < sh_total && sh_rl[sh_cursor] == 0)
                sh_cursor++;
            if (sh_cursor >= sh_total) return 0;
            granted = sh_rs[sh_cursor];
            sh_rs[sh_cursor]++;
            sh_rl[sh_cursor]--;
            if (sh_rl[sh_cursor] == 0) sh_cursor++;
            return 1;
        end
        if (n == 0) n = 1;
        for (int unsigned k = sh_cursor; k < sh_total; k++)
        begin
            if (sh_rl[k] >= n)
            begin
                bid = sh_rs[k];
                sh_rs[k] += n;
                sh_rl[k] -= n;
                if (sh_rl[k] == 0) sh_cursor++;
                if (bid < NBLK) sh_mark[bid] = 1;
                for (int unsigned i = 0; i < n; i++)
                    if (bid + i < NBLK) sh_len[bid+i] = 0;
                if (bid < NBLK) sh_len[bid] = n[7:0];
                granted = bid;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic out_item_t predict_grant(in_item_t it);
        out_item_t r;
        int unsigned g;
        r = '0;
        case (it.cmd)
            CMD_INIT:
            begin
                for (int i = 0; i < NBLK; i++)
                begin
                    sh_mark[i] = 0;
                    sh_len[i] = 0;
                end
                sh_total = 0;
                sh_cursor = 0;
                sh_pending = 0;
                if (sh_first < page_last()) push_run(sh_first, page_last() - sh_first);
            end
            CMD_ALLOC:
            begin
                if (take_blocks(it.block_count, g))
                    r.granted_block = g[9:0];
                else
                    r.status = 1'b1;
            end
            CMD_BEGIN_MARK:
            begin
                for (int i = 0; i < NBLK; i++) sh_mark[i] = 0;
                sh_pending = 1;
            end
            CMD_MARK: sh_mark[it.block_index] = 1;
            CMD_SWEEP: if (sh_pending) rebuild_runs();
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stall as seen at the rising edge decides acceptance.
    logic in_stall_seen;
    always @(posedge clk) in_stall_seen <= in_stall;

    // Driver: bursts and gaps, changes on the falling edge.
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_seen)
            begin
                // Beat was taken at the last rising edge.
                void'(pending_items.pop_front());
            end
            if (gap_left > 0 || hold_sender)
            begin
                if (!(in_valid && in_stall_seen))
                    in_valid <= 0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
            else if (in_valid && in_stall_seen)
                ;
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1;
                in_data <= pending_items[0];
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 0;
        end
    end

    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            expected_grants.push_back(predict_grant(in_data));

    // Receiver stall pattern and monitor.
    int stall_phase;
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[8])
            out_stall <= 0;
        else
            out_stall <= ($urandom_range(0, 3) == 0) || (stall_phase[5:3] == 3'd5);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_grants.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                out_item_t w;
                w = expected_grants.pop_front();
                if (out_data.status !== w.status)
                    report_mismatch("status", out_data.status, w.status);
                if (out_data.granted_block !== w.granted_block)
                    report_mismatch("granted_block", out_data.granted_block, w.granted_block);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_VAR_MODE: sh_var_mode = val[0];
            CFG_FIRST_USABLE: sh_first = val[9:0];
            CFG_PAGE_BLOCKS: sh_pages = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_grants.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    function automatic in_item_t mk(logic [2:0] c, logic [7:0] n, logic [9:0] b);
        in_item_t it;
        it.cmd = c;
        it.block_count = n;
        it.block_index = b;
        return it;
    endfunction

    task automatic random_phase(int items);
        int unsigned lo, hi;
        lo = sh_first;
        hi = page_last();
        pending_items.push_back(mk(CMD_INIT, 8'd0, 10'd0));
        for (int i = 0; i < items; i++)
        begin
            int unsigned r;
            r = $urandom_range(0, 99);
            if (r < 45)
                pending_items.push_back(mk(CMD_ALLOC,
                    8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(1, 12)),
                    10'($urandom)));
            else if (r < 50)
                pending_items.push_back(mk(CMD_BEGIN_MARK, 8'($urandom), 10'($urandom)));
            else if (r < 80)
                pending_items.push_back(mk(CMD_MARK, 8'($urandom),
                    10'(($urandom_range(0, 7) == 0 || hi <= lo) ? $urandom_range(0, 1023)
                                                               : $urandom_range(lo, hi - 1))));
            else if (r < 86)
                pending_items.push_back(mk(CMD_SWEEP, 8'($urandom), 10'($urandom)));
            else if (r < 89)
                pending_items.push_back(mk(3'($urandom_range(5, 7)), 8'($urandom),
                    10'($urandom)));
            else if (r < 91)
                pending_items.push_back(mk(CMD_INIT, 8'($urandom), 10'($urandom)));
            else
                pending_items.push_back(mk(CMD_ALLOC, 8'($urandom_range(1, 4)),
                    10'($urandom)));
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        hold_sender = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        sh_var_mode = 1;
        sh_first = 0;
        sh_pages = PAGE_BLOCKS_RST;
        for (int i = 0; i < NBLK; i++)
        begin
            sh_mark[i] = 0;
            sh_len[i] = 0;
        end
        for (int i = 0; i < NRUN; i++)
        begin
            sh_rs[i] = 0;
            sh_rl[i] = 0;
        end
        sh_total = 0;
        sh_cursor = 0;
        sh_pending = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: allocate before init, extremes, unknown commands, empty sweep.
        pending_items.push_back(mk(CMD_ALLOC, 8'd5, 10'd0));
        pending_items.push_back(mk(CMD_SWEEP, 8'd0, 10'd0));
        pending_items.push_back(mk(CMD_INIT, 8'hFF, 10'h3FF));
        pending_items.push_back(mk(CMD_ALLOC, 8'd0, 10'd0));
        pending_items.push_back(mk(CMD_ALLOC, 8'd255, 10'h3FF));
        pending_items.push_back(mk(CMD_ALLOC, 8'd255, 10'd0));
        pending_items.push_back(mk(CMD_ALLOC, 8'd1, 10'd0));
        pending_items.push_back(mk(CMD_BEGIN_MARK, 8'd0, 10'd0));
        pending_items.push_back(mk(CMD_MARK, 8'd0, 10'd0));
        pending_items.push_back(mk(CMD_MARK, 8'd0, 10'd256));
        pending_items.push_back(mk(CMD_MARK, 8'd0, 10'h3FF));
        pending_items.push_back(mk(CMD_SWEEP, 8'd0, 10'd0));
        pending_items.push_back(mk(CMD_SWEEP, 8'd0, 10'd0));
        pending_items.push_back(mk(CMD_ALLOC, 8'd200, 10'd0));
        pending_items.push_back(mk(3'd5, 8'd0, 10'd0));
        pending_items.push_back(mk(3'd6, 8'hAA, 10'h155));
        pending_items.push_back(mk(3'd7, 8'h55, 10'h2AA));
        pending_items.push_back(mk(CMD_BEGIN_MARK, 8'd0, 10'd0));
        pending_items.push_back(mk(CMD_ALLOC, 8'd3, 10'd0));
        wait_idle();

        // The sender is held off with an item queued, then released.
        hold_sender = 1;
        pending_items.push_back(mk(CMD_ALLOC, 8'd2, 10'd0));
        repeat (50) @(posedge clk);
        hold_sender = 0;
        wait_idle();

        // Tiny page, empty page, oversize page, first usable past end.
        write_reg(CFG_PAGE_BLOCKS, 11'd1);
        write_reg(CFG_FIRST_USABLE, 11'd0);
        random_phase(40);
        write_reg(CFG_PAGE_BLOCKS, 11'd0);
        random_phase(20);
        write_reg(CFG_PAGE_BLOCKS, 11'h7FF);
        write_reg(CFG_FIRST_USABLE, 11'h3FF);
        random_phase(40);
        write_reg(CFG_FIRST_USABLE, 11'd40);
        write_reg(CFG_PAGE_BLOCKS, 11'd30);
        random_phase(20);

        for (int ph = 0; ph < 16; ph++)
        begin
            write_reg(CFG_VAR_MODE, CFG_DATA_W'(ph[0]));
            write_reg(CFG_FIRST_USABLE, CFG_DATA_W'($urandom_range(0, 24)));
            write_reg(CFG_PAGE_BLOCKS,
                (ph % 4 == 3) ? 11'd1024 : CFG_DATA_W'($urandom_range(16, 120)));
            random_phase(110);
        end
        write_reg(CFG_VAR_MODE, 11'd0);
        write_reg(CFG_FIRST_USABLE, 11'd1);
        write_reg(CFG_PAGE_BLOCKS, 11'd1024);
        random_phase(60);

        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> filelist.f
design/gcpfra_pkg.sv
design/gcpfra_dp.sv
design/gcpfra_ctrl.sv
design/gc_page_free_run_allocator.sv
design/gcpfra_checker.sv
tb/sv/tb.sv
